// ===== src/nps_pkg.sv =====
// Shared types and constants for the nearest palette color search block.
package nps_pkg;

   // Request kinds carried in the request tuser bit.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Field widths of the request and response items.
   localparam int COMP_W  = 8;
   localparam int INDEX_W = 8;
   localparam int DIST_W  = 18;
   localparam int SQ_W    = 2 * COMP_W;
   localparam int COLOR_W = 3 * COMP_W;

   // Largest squared distance, three components of 255 each.
   localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

   // Sequencer states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

// ===== src/nps_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module nps_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/nearest_palette_color_search.sv =====
// Top level of the nearest palette color search: palette RAM, scan pipeline and sequencer.
//
//   Channel  Direction  Ports             Contents
//   req      in         req_t*            load of one palette entry, or a color query
//   rsp      out        rsp_t*            nearest index, its squared distance, exact flag
//
// A load writes the palette RAM directly when it is taken; it gives no response.
// A query scans every palette entry: the scan reads one palette entry per cycle
// from the single RAM read port, through a three-stage square and compare pipeline.
// The request side is ready only while the sequencer is idle; a finished response may
// wait in the output register while the next request is taken.
// Reset clears the sequencer and the response valid; the palette RAM is not cleared.
module nearest_palette_color_search #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic        req_tuser,  // req_type[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // best_index[7:0], best_distance[25:8], zero[31:26]
   output logic        rsp_tuser   // exact_match[0]
);

   import nps_pkg::*;

   localparam int ADDR_W = $clog2(PALETTE_ENTRIES);
   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(PALETTE_ENTRIES - 1);
   localparam logic [INDEX_W:0] ENTRY_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

   // Request fields.
   logic [INDEX_W-1:0] req_index;
   logic [COMP_W-1:0]  req_red;
   logic [COMP_W-1:0]  req_green;
   logic [COMP_W-1:0]  req_blue;
   logic               req_fire;

   state_type state_ff, state_in;

   // Query color held during the scan.
   logic [COMP_W-1:0] q_red_ff, q_green_ff, q_blue_ff;

   // Address issue stage.
   logic [ADDR_W-1:0] scan_addr_ff, scan_addr_in;
   logic              issuing_ff, issuing_in;

   // Stage 1: RAM read in flight.
   logic              s1_valid_ff;
   logic              s1_last_ff;
   logic [ADDR_W-1:0] s1_idx_ff;

   // Stage 2: per-component squares.
   logic              s2_valid_ff;
   logic              s2_last_ff;
   logic [ADDR_W-1:0] s2_idx_ff;
   logic [SQ_W-1:0]   sq_red_ff, sq_green_ff, sq_blue_ff;

   // Running best.
   logic [ADDR_W-1:0] best_idx_ff;
   logic [DIST_W-1:0] best_dist_ff;

   // Response register.
   logic              rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_index_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_exact_ff;
   logic              rsp_load;

   // Palette RAM ports.
   logic              wr_en;
   logic [COLOR_W-1:0] wr_data;
   logic              rd_en;
   logic [COLOR_W-1:0] rd_data;

   // Stage 2 combinational values.
   logic [COMP_W-1:0] diff_red, diff_green, diff_blue;
   logic [COMP_W-1:0] ent_red, ent_green, ent_blue;

   // Stage 3 combinational values.
   logic [DIST_W-1:0] sum_dist;
   logic              take;

   assign req_index = req_tdata[7:0];
   assign req_red   = req_tdata[15:8];
   assign req_green = req_tdata[23:16];
   assign req_blue  = req_tdata[31:24];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Loads write the palette when the index is inside the palette.
   assign wr_en   = req_fire && (req_tuser == REQ_LOAD) && ({1'b0, req_index} < ENTRY_LIMIT);
   assign wr_data = {req_red, req_green, req_blue};

   assign rd_en = (state_ff == ST_SCAN) && issuing_ff;

   nps_ram #(
      .WIDTH(COLOR_W),
      .DEPTH(PALETTE_ENTRIES)
   ) u_palette (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_index[ADDR_W-1:0]),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(scan_addr_ff),
      .rd_data(rd_data)
   );

   // Absolute component differences against the entry just read.
   assign ent_red    = rd_data[23:16];
   assign ent_green  = rd_data[15:8];
   assign ent_blue   = rd_data[7:0];
   assign diff_red   = (q_red_ff > ent_red) ? (q_red_ff - ent_red) : (ent_red - q_red_ff);
   assign diff_green = (q_green_ff > ent_green) ? (q_green_ff - ent_green)
                                                : (ent_green - q_green_ff);
   assign diff_blue  = (q_blue_ff > ent_blue) ? (q_blue_ff - ent_blue) : (ent_blue - q_blue_ff);

   // Sum of squares and compare; the first entry always takes, ties keep the lower index.
   assign sum_dist = DIST_W'(sq_red_ff) + DIST_W'(sq_green_ff) + DIST_W'(sq_blue_ff);
   assign take = s2_valid_ff && ((s2_idx_ff == '0) || (sum_dist < best_dist_ff));

   // The response register loads when the scan result is ready and the slot is free.
   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // Sequencer and address counter next-state logic.
   always_comb begin
      state_in     = state_ff;
      scan_addr_in = scan_addr_ff;
      issuing_in   = issuing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_tuser == REQ_QUERY)) begin
               state_in     = ST_SCAN;
               scan_addr_in = '0;
               issuing_in   = 1'b1;
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               if (scan_addr_ff == LAST_IDX) begin
                  issuing_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + 1'b1;
               end
            end
            if (s2_valid_ff && s2_last_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         issuing_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         issuing_ff  <= issuing_in;
         s1_valid_ff <= rd_en;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // Scan datapath registers.
   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      if (req_fire) begin
         q_red_ff   <= req_red;
         q_green_ff <= req_green;
         q_blue_ff  <= req_blue;
      end
      s1_idx_ff   <= scan_addr_ff;
      s1_last_ff  <= (scan_addr_ff == LAST_IDX);
      s2_idx_ff   <= s1_idx_ff;
      s2_last_ff  <= s1_last_ff;
      sq_red_ff   <= diff_red * diff_red;
      sq_green_ff <= diff_green * diff_green;
      sq_blue_ff  <= diff_blue * diff_blue;
      if (take) begin
         best_idx_ff  <= s2_idx_ff;
         best_dist_ff <= sum_dist;
      end
   end

   // Response valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_index_ff <= INDEX_W'(best_idx_ff);
         rsp_dist_ff  <= best_dist_ff;
         rsp_exact_ff <= (best_dist_ff == '0);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_dist_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_exact_ff;

   // A response only appears after the sequencer has finished a scan.
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised without a finished scan");

   // The exact flag agrees with the reported distance.
   a_exact_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_exact_ff == (rsp_dist_ff == '0)))
      else $error("exact flag disagrees with distance");

   // The reported distance never exceeds the largest possible squared distance.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_dist_ff <= MAX_DIST))
      else $error("distance out of range");

   // The pipeline only carries entries while a scan is running.
   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff || s2_valid_ff) |-> (state_ff == ST_SCAN))
      else $error("scan pipeline active outside a scan");

endmodule

// ===== bench/nearest_palette_color_search_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest palette color search block.
module nearest_palette_color_search_tb;
   import nps_pkg::*;

   localparam int PALETTE_ENTRIES = 256;
   localparam int DIRECTED_ROWS   = 24;
   localparam int RANDOM_ITEMS    = 270;
   localparam int CYCLE_LIMIT     = 600000;
   localparam int HOLD_AFTER      = 30;
   localparam int HOLD_CYCLES     = 3000;
   localparam int TAIL_CYCLES     = PALETTE_ENTRIES + 16;
   localparam int MAX_GAP         = 40;

   // Where the expected answer of a stimulus row comes from.
   localparam logic TYPED     = 1'b1;
   localparam logic PREDICTED = 1'b0;

   // One answer of the block: nearest index, its squared distance, exact flag.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [DIST_W-1:0]  distance;
      logic               exact;
   } match_type;

   localparam match_type NO_MATCH = '0;

   // One request, with its answer where that is typed in by hand.
   typedef struct packed {
      logic               kind;
      logic [INDEX_W-1:0] entry;
      logic [COMP_W-1:0]  red;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  blue;
      logic               source;
      match_type          want;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;  // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   logic        req_tuser  = 1'b0; // req_type[0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // best_index[7:0], best_distance[25:8], zero[31:26]
   logic        rsp_tuser;        // exact_match[0]

   // Shadow copy of the palette and the answers still owed by the block.
   logic [COLOR_W-1:0] palette_copy [PALETTE_ENTRIES];
   match_type          pending_matches [$];

   int send_idle_pct = 34;
   int recv_idle_pct = 50;
   int error_count   = 0;
   int match_count   = 0;
   int exact_count   = 0;
   int load_count    = 0;
   int query_count   = 0;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_done     = 1'b0;

   nearest_palette_color_search #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // Free-running clock, 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Scan the shadow palette for the closest color; the lowest index wins ties.
   function automatic match_type nearest_entry(input logic [COMP_W-1:0] red,
                                               input logic [COMP_W-1:0] green,
                                               input logic [COMP_W-1:0] blue);
      match_type best;
      int        best_dist;
      int        cand_dist;
      int        dr;
      int        dg;
      int        db;
      best      = NO_MATCH;
      best_dist = int'(MAX_DIST) + 1;
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         dr        = int'(red)   - int'(palette_copy[i][2*COMP_W +: COMP_W]);
         dg        = int'(green) - int'(palette_copy[i][COMP_W +: COMP_W]);
         db        = int'(blue)  - int'(palette_copy[i][0 +: COMP_W]);
         cand_dist = dr * dr + dg * dg + db * db;
         if (cand_dist < best_dist) begin
            best_dist  = cand_dist;
            best.index = INDEX_W'(i);
         end
      end
      best.distance = DIST_W'(best_dist);
      best.exact    = (best_dist == 0);
      return best;
   endfunction

   // Offer one request after a random gap and wait for its transfer.
   task automatic push_request(input stim_row_type row);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.kind;
      req_tdata  <= {row.blue, row.green, row.red, row.entry};
      do @(posedge clock); while (!req_tready);
      if (row.kind == REQ_LOAD) begin
         palette_copy[row.entry] = {row.red, row.green, row.blue};
         load_count++;
      end else begin
         if (row.source == TYPED) begin
            pending_matches.push_back(row.want);
         end else begin
            pending_matches.push_back(nearest_entry(row.red, row.green, row.blue));
         end
         query_count++;
      end
   endtask

   // Response side: check each transfer, then decide the next ready.
   always @(posedge clock) begin
      match_type want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_matches.size() == 0) begin
            $error("unexpected response: best_index %0d, best_distance %0d",
                   rsp_tdata[7:0], rsp_tdata[25:8]);
            error_count++;
         end else begin
            want = pending_matches.pop_front();
            if (rsp_tdata[7:0] !== want.index) begin
               $error("best_index: expected %0d, actual %0d", want.index, rsp_tdata[7:0]);
               error_count++;
            end
            if (rsp_tdata[25:8] !== want.distance) begin
               $error("best_distance: expected %0d, actual %0d",
                      want.distance, rsp_tdata[25:8]);
               error_count++;
            end
            if (rsp_tuser !== want.exact) begin
               $error("exact_match: expected %0d, actual %0d", want.exact, rsp_tuser);
               error_count++;
            end
            match_count++;
            if (want.exact) exact_count++;
         end
      end

      // One long hold-off so that the block backs up into its request side.
      if (!hold_done && match_count == HOLD_AFTER) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles, %0d responses still owed.",
                  cycle_count, pending_matches.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Stimulus: reset, palette fill, directed table, then random traffic.
   initial begin
      stim_row_type       directed_rows [DIRECTED_ROWS];
      stim_row_type       row;
      logic [COLOR_W-1:0] color;
      int                 pick;

      directed_rows = '{
         // Whole palette white: farthest possible query, then an all-way tie.
         '{REQ_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   TYPED, '{8'd0, MAX_DIST, 1'b0}},
         '{REQ_QUERY, 8'd0,   8'd255, 8'd255, 8'd255, TYPED, '{8'd0, 18'd0, 1'b1}},
         // Top entry turned black.
         '{REQ_LOAD,  8'd255, 8'd0,   8'd0,   8'd0,   PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd0,   8'd0,   8'd0,   TYPED, '{8'd255, 18'd0, 1'b1}},
         '{REQ_LOAD,  8'd0,   8'd0,   8'd0,   8'd1,   PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd0,   8'd0,   8'd2,   TYPED, '{8'd0, 18'd1, 1'b0}},
         // Pure primaries; two equal reds so the lower index must win.
         '{REQ_LOAD,  8'd100, 8'd255, 8'd0,   8'd0,   PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd255, 8'd255, 8'd0,   8'd0,   TYPED, '{8'd100, 18'd0, 1'b1}},
         '{REQ_LOAD,  8'd50,  8'd255, 8'd0,   8'd0,   PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd255, 8'd0,   8'd0,   TYPED, '{8'd50, 18'd0, 1'b1}},
         '{REQ_LOAD,  8'd20,  8'd0,   8'd255, 8'd0,   PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd0,   8'd255, 8'd0,   TYPED, '{8'd20, 18'd0, 1'b1}},
         '{REQ_LOAD,  8'd30,  8'd0,   8'd0,   8'd255, PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd0,   8'd0,   8'd255, TYPED, '{8'd30, 18'd0, 1'b1}},
         // Tie at a nonzero distance between two neighbors.
         '{REQ_LOAD,  8'd10,  8'd100, 8'd100, 8'd100, PREDICTED, NO_MATCH},
         '{REQ_LOAD,  8'd11,  8'd102, 8'd100, 8'd100, PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd101, 8'd100, 8'd100, TYPED, '{8'd10, 18'd1, 1'b0}},
         '{REQ_QUERY, 8'd0,   8'd200, 8'd0,   8'd0,   TYPED, '{8'd50, 18'd3025, 1'b0}},
         // Mixed colors checked by the predictor.
         '{REQ_QUERY, 8'd0,   8'd128, 8'd64,  8'd32,  PREDICTED, NO_MATCH},
         '{REQ_LOAD,  8'd254, 8'd127, 8'd128, 8'd129, PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd0,   8'd127, 8'd128, 8'd130, PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd170, 8'd170, 8'd85,  8'd170, PREDICTED, NO_MATCH},
         '{REQ_LOAD,  8'd1,   8'd85,  8'd170, 8'd85,  PREDICTED, NO_MATCH},
         '{REQ_QUERY, 8'd85,  8'd86,  8'd170, 8'd84,  PREDICTED, NO_MATCH}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Every entry is written before the first query scans the palette.
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         row       = '0;
         row.kind  = REQ_LOAD;
         row.entry = INDEX_W'(i);
         row.red   = 8'hFF;
         row.green = 8'hFF;
         row.blue  = 8'hFF;
         push_request(row);
      end

      foreach (directed_rows[i]) push_request(directed_rows[i]);

      // Random traffic in three idling mixes.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 50;
            recv_idle_pct = 34;
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         row        = '0;
         row.source = PREDICTED;
         row.entry  = INDEX_W'($urandom);
         row.red    = COMP_W'($urandom);
         row.green  = COMP_W'($urandom);
         row.blue   = COMP_W'($urandom);
         pick       = $urandom_range(99);
         color      = palette_copy[$urandom_range(PALETTE_ENTRIES - 1)];
         if ($urandom_range(99) < 40) begin
            // Queries: exact hits, near misses and free colors.
            row.kind = REQ_QUERY;
            if (pick < 30) begin
               {row.red, row.green, row.blue} = color;
            end else if (pick < 50) begin
               row.red   = color[2*COMP_W +: COMP_W] + COMP_W'($urandom_range(4)) - 8'd2;
               row.green = color[COMP_W +: COMP_W]   + COMP_W'($urandom_range(4)) - 8'd2;
               row.blue  = color[0 +: COMP_W]        + COMP_W'($urandom_range(4)) - 8'd2;
            end
         end else begin
            // Loads: duplicates of other entries make ties, plus corner colors.
            row.kind = REQ_LOAD;
            if (pick < 15) begin
               {row.red, row.green, row.blue} = color;
            end else if (pick < 25) begin
               row.red   = $urandom_range(1) ? 8'hFF : 8'h00;
               row.green = $urandom_range(1) ? 8'hFF : 8'h00;
               row.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            end
         end
         push_request(row);
      end
      req_tvalid <= 1'b0;

      // Drain the owed answers, then give the block time to show anything extra.
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d palette loads and %0d color queries, %0d of them exact hits.",
               load_count, query_count, exact_count);
      $display("Traffic ran in three stall mixes with one %0d-cycle response hold-off.",
               HOLD_CYCLES);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
